// ----- src/stuffed_bit_writer_unit_defines.svh -----
// assertion macros used by the bit writer unit
`ifndef STUFFED_BIT_WRITER_UNIT_DEFINES_SVH
`define STUFFED_BIT_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, held off while reset is low
`define SBW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stuffed bit writer check failed");
// clocked check that also runs during reset
`define SBW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("stuffed bit writer check failed");
`else
`define SBW_ASSERT(label, clk, rst_n, prop)
`define SBW_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- src/sbw_pkg.sv -----
`default_nettype none

package sbw_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_FLUSH   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic CFG_BYTE_CAPACITY = 1'b0;
    localparam logic CFG_SIMULATE_ONLY = 1'b1;

    localparam logic [7:0]  BYTE_MARKER  = 8'hff;
    localparam logic [3:0]  FREE_FULL    = 4'd8;
    localparam logic [3:0]  FREE_STUFFED = 4'd7;
    localparam logic [5:0]  MAX_NBITS    = 6'd32;
    localparam logic [31:0] CAPACITY_RST = 32'd65535;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        stored;
        logic        dropped;
        logic [31:0] byte_position;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ----- src/sbw_out_stage.sv -----
`default_nettype none

module sbw_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire sbw_pkg::t_result i_result,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sbw_pkg::t_result      o_result
);
    import sbw_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // a slot frees up in the same cycle the receiver takes it
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- src/stuffed_bit_writer_unit.sv -----
// stuffed bit writer: packs msb-first bit fields into bytes with packet
// header bit stuffing (a byte after 0xff carries only 7 data bits)
// input channel: i_in_valid / o_in_ready with i_kind, i_value, i_nbits
//   kind write packs the low nbits of value, flush emits the partial byte
//   (plus one more if it was 0xff), restart clears position and buffer
// output channel: o_out_valid / i_out_ready, one item per emitted byte,
//   o_last marks the final byte caused by an input item
// config channel: i_cfg_valid / o_cfg_ready, index 0 byte capacity,
//   index 1 simulate-only; always ready, write only while idle
// sequencing: a write item keeps the sequencer busy, first shifting the
//   value shift register to align the field and then placing one bit per
//   cycle unless a stalled output holds it; flush stays busy for its byte
//   and any stuffed byte; restart, zero-length writes and the unused kind stay idle
// an emitted byte shows on o_out_valid the cycle after it is emitted
// o_in_ready is high only between items; one item is worked on at a time
// results sit in a single output register; when the receiver stalls with
//   that register full, the bit sequencer holds on the next emitting cycle
// reset (synchronous, active low): capacity 65535, simulate off,
//   buffer empty with 8 bits free, position zero, no output pending
`default_nettype none

`include "stuffed_bit_writer_unit_defines.svh"

module stuffed_bit_writer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_value,
    input  wire logic [5:0]  i_nbits,
    // byte output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_stored,
    output logic             o_dropped,
    output logic [31:0]      o_byte_position,
    output logic             o_last,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import sbw_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BITS   = 2'd1;
    localparam logic [1:0] ST_FLUSH1 = 2'd2;
    localparam logic [1:0] ST_FLUSH2 = 2'd3;

    logic [1:0]  r_state,  n_state;
    logic [31:0] r_shift,  n_shift;   // value, msb of the field leaves at bit 31
    logic [5:0]  r_skip,   n_skip;    // alignment cycles still to go
    logic [5:0]  r_left,   n_left;    // field bits still to place
    logic [7:0]  r_buf,    n_buf;     // partial byte
    logic [3:0]  r_free,   n_free;    // free bit slots in r_buf
    logic [31:0] r_pos,    n_pos;     // bytes counted
    logic [31:0] r_cap,    n_cap;
    logic        r_sim,    n_sim;

    logic        w_accept;
    logic [5:0]  w_nbits;
    logic        w_is_ff;
    logic [3:0]  w_new_free;
    logic        w_drop;
    logic [31:0] w_pos_inc;
    logic        w_bit_emit;
    logic        w_emit;
    logic        w_can_load;
    logic        w_fire;
    logic        w_last;
    logic [7:0]  w_buf_pre;
    logic [3:0]  w_free_pre;
    logic [3:0]  w_free_post;
    t_result     w_result;
    t_result     w_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_nbits     = (i_nbits > MAX_NBITS) ? MAX_NBITS : i_nbits;

    // byte emission, shared by bit placement and flush
    assign w_is_ff    = (r_buf == BYTE_MARKER);
    assign w_new_free = w_is_ff ? FREE_STUFFED : FREE_FULL;
    assign w_drop     = (r_pos >= r_cap);
    assign w_pos_inc  = r_pos + 32'd1;

    // a bit arriving at a full buffer pushes the byte out first
    assign w_bit_emit = (r_state == ST_BITS) && (r_skip == 6'd0) && (r_free == 4'd0);
    assign w_emit     = w_bit_emit || (r_state == ST_FLUSH1) || (r_state == ST_FLUSH2);
    assign w_fire     = w_emit && w_can_load;

    // last byte of the item: during a write, when the bits after this one
    // fit in the fresh byte; on flush, when no stuffed byte follows
    always_comb begin
        unique case (r_state)
            ST_BITS:   w_last = ((r_left - 6'd1) < {2'b00, w_new_free});
            ST_FLUSH1: w_last = !w_is_ff;
            default:   w_last = 1'b1;
        endcase
    end

    assign w_result.out_byte      = r_buf;
    assign w_result.stored        = !w_drop && !r_sim;
    assign w_result.dropped       = w_drop;
    assign w_result.byte_position = w_drop ? r_pos : w_pos_inc;
    assign w_result.last          = w_last;

    // buffer and slot count as seen by the incoming bit
    assign w_buf_pre   = (w_bit_emit && !w_drop) ? 8'd0 : r_buf;
    assign w_free_pre  = w_bit_emit ? w_new_free : r_free;
    assign w_free_post = w_free_pre - 4'd1;

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_skip  = r_skip;
        n_left  = r_left;
        n_buf   = r_buf;
        n_free  = r_free;
        n_pos   = r_pos;
        n_cap   = r_cap;
        n_sim   = r_sim;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTE_CAPACITY: n_cap = i_cfg_data;
                CFG_SIMULATE_ONLY: n_sim = i_cfg_data[0];
                default:           n_cap = r_cap;
            endcase
        end

        // emitted byte updates the buffer state
        if (w_fire) begin
            n_free = w_new_free;
            if (!w_drop) begin
                n_pos = w_pos_inc;
                n_buf = 8'd0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_WRITE: begin
                            if (w_nbits != 6'd0) begin
                                n_shift = i_value;
                                n_skip  = MAX_NBITS - w_nbits;
                                n_left  = w_nbits;
                                n_state = ST_BITS;
                            end
                        end
                        KIND_FLUSH: begin
                            n_state = ST_FLUSH1;
                        end
                        KIND_RESTART: begin
                            n_pos  = 32'd0;
                            n_buf  = 8'd0;
                            n_free = FREE_FULL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BITS: begin
                if (r_skip != 6'd0) begin
                    n_shift = {r_shift[30:0], 1'b0};
                    n_skip  = r_skip - 6'd1;
                end else if (!w_bit_emit || w_can_load) begin
                    n_free  = w_free_post;
                    n_buf   = w_buf_pre | ({7'd0, r_shift[31]} << w_free_post[2:0]);
                    n_shift = {r_shift[30:0], 1'b0};
                    n_left  = r_left - 6'd1;
                    if (r_left == 6'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH1: begin
                if (w_can_load) begin
                    n_state = w_is_ff ? ST_FLUSH2 : ST_IDLE;
                end
            end
            ST_FLUSH2: begin
                if (w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_buf   <= 8'd0;
            r_free  <= FREE_FULL;
            r_pos   <= 32'd0;
            r_cap   <= CAPACITY_RST;
            r_sim   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_free  <= n_free;
            r_pos   <= n_pos;
            r_cap   <= n_cap;
            r_sim   <= n_sim;
        end
    end

    // field shifter, no reset needed
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_skip  <= n_skip;
        r_left  <= n_left;
    end

    sbw_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (w_out)
    );

    assign o_out_byte      = w_out.out_byte;
    assign o_stored        = w_out.stored;
    assign o_dropped       = w_out.dropped;
    assign o_byte_position = w_out.byte_position;
    assign o_last          = w_out.last;

    // slot count never exceeds a full byte
    `SBW_ASSERT(a_free_range, i_clk, i_rst_n, r_free <= FREE_FULL)
    // a byte is only pushed when the output register can take it
    `SBW_ASSERT(a_no_overrun, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |-> !w_fire)
    // restart returns the bit state to its reset values
    `SBW_ASSERT(a_restart, i_clk, i_rst_n,
        (w_accept && (i_kind == KIND_RESTART)) |=>
        ((r_pos == 32'd0) && (r_free == FREE_FULL) && (r_buf == 8'd0)))
    // a dropped byte never leaves the position moving
    `SBW_ASSERT(a_drop_holds_pos, i_clk, i_rst_n, (w_fire && w_drop) |=> $stable(r_pos))
    // holding reset leaves the sequencer idle
    `SBW_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE))

endmodule

`default_nettype wire
